// File: hw/rtl/sha512_stream_hasher_macros.svh
// Assertion macros used by the checker file of the SHA-512 stream hasher.
`ifndef SHA512_STREAM_HASHER_MACROS_SVH
`define SHA512_STREAM_HASHER_MACROS_SVH

// Checked on every clock edge while reset is released.
`define SHA512SH_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset or not.
`define SHA512SH_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/sha512sh_pkg.sv
// Types, constants and helper functions of the SHA-512 stream hasher.
package sha512sh_pkg;

    typedef logic [63:0] t_word;
    typedef logic [7:0]  t_byte;
    typedef logic [6:0]  t_fill;
    typedef logic [6:0]  t_round;
    typedef logic [2:0]  t_widx;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
        t_word f;
        t_word g;
        t_word h;
    } t_work;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD_ONE,
        S_PAD_ZERO,
        S_PAD_LEN,
        S_ROUND,
        S_FINAL,
        S_OUT
    } t_state;

    localparam t_byte  PAD_BYTE   = 8'h80;
    localparam t_fill  LEN_OFFSET = 7'd112;
    localparam t_fill  FILL_LAST  = 7'd127;
    localparam t_round ROUND_LAST = 7'd79;
    localparam t_widx  WORD_LAST  = 3'd7;

    function automatic t_word rotr64(input t_word x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic t_word iv_word(input t_widx idx);
        t_word v;
        case (idx)
            3'd0:    v = 64'h6a09e667f3bcc908;
            3'd1:    v = 64'hbb67ae8584caa73b;
            3'd2:    v = 64'h3c6ef372fe94f82b;
            3'd3:    v = 64'ha54ff53a5f1d36f1;
            3'd4:    v = 64'h510e527fade682d1;
            3'd5:    v = 64'h9b05688c2b3e6c1f;
            3'd6:    v = 64'h1f83d9abfb41bd6b;
            default: v = 64'h5be0cd19137e2179;
        endcase
        return v;
    endfunction

    function automatic t_word round_k(input t_round idx);
        t_word v;
        case (idx)
            7'd0:  v = 64'h428a2f98d728ae22;
            7'd1:  v = 64'h7137449123ef65cd;
            7'd2:  v = 64'hb5c0fbcfec4d3b2f;
            7'd3:  v = 64'he9b5dba58189dbbc;
            7'd4:  v = 64'h3956c25bf348b538;
            7'd5:  v = 64'h59f111f1b605d019;
            7'd6:  v = 64'h923f82a4af194f9b;
            7'd7:  v = 64'hab1c5ed5da6d8118;
            7'd8:  v = 64'hd807aa98a3030242;
            7'd9:  v = 64'h12835b0145706fbe;
            7'd10: v = 64'h243185be4ee4b28c;
            7'd11: v = 64'h550c7dc3d5ffb4e2;
            7'd12: v = 64'h72be5d74f27b896f;
            7'd13: v = 64'h80deb1fe3b1696b1;
            7'd14: v = 64'h9bdc06a725c71235;
            7'd15: v = 64'hc19bf174cf692694;
            7'd16: v = 64'he49b69c19ef14ad2;
            7'd17: v = 64'hefbe4786384f25e3;
            7'd18: v = 64'h0fc19dc68b8cd5b5;
            7'd19: v = 64'h240ca1cc77ac9c65;
            7'd20: v = 64'h2de92c6f592b0275;
            7'd21: v = 64'h4a7484aa6ea6e483;
            7'd22: v = 64'h5cb0a9dcbd41fbd4;
            7'd23: v = 64'h76f988da831153b5;
            7'd24: v = 64'h983e5152ee66dfab;
            7'd25: v = 64'ha831c66d2db43210;
            7'd26: v = 64'hb00327c898fb213f;
            7'd27: v = 64'hbf597fc7beef0ee4;
            7'd28: v = 64'hc6e00bf33da88fc2;
            7'd29: v = 64'hd5a79147930aa725;
            7'd30: v = 64'h06ca6351e003826f;
            7'd31: v = 64'h142929670a0e6e70;
            7'd32: v = 64'h27b70a8546d22ffc;
            7'd33: v = 64'h2e1b21385c26c926;
            7'd34: v = 64'h4d2c6dfc5ac42aed;
            7'd35: v = 64'h53380d139d95b3df;
            7'd36: v = 64'h650a73548baf63de;
            7'd37: v = 64'h766a0abb3c77b2a8;
            7'd38: v = 64'h81c2c92e47edaee6;
            7'd39: v = 64'h92722c851482353b;
            7'd40: v = 64'ha2bfe8a14cf10364;
            7'd41: v = 64'ha81a664bbc423001;
            7'd42: v = 64'hc24b8b70d0f89791;
            7'd43: v = 64'hc76c51a30654be30;
            7'd44: v = 64'hd192e819d6ef5218;
            7'd45: v = 64'hd69906245565a910;
            7'd46: v = 64'hf40e35855771202a;
            7'd47: v = 64'h106aa07032bbd1b8;
            7'd48: v = 64'h19a4c116b8d2d0c8;
            7'd49: v = 64'h1e376c085141ab53;
            7'd50: v = 64'h2748774cdf8eeb99;
            7'd51: v = 64'h34b0bcb5e19b48a8;
            7'd52: v = 64'h391c0cb3c5c95a63;
            7'd53: v = 64'h4ed8aa4ae3418acb;
            7'd54: v = 64'h5b9cca4f7763e373;
            7'd55: v = 64'h682e6ff3d6b2b8a3;
            7'd56: v = 64'h748f82ee5defb2fc;
            7'd57: v = 64'h78a5636f43172f60;
            7'd58: v = 64'h84c87814a1f0ab72;
            7'd59: v = 64'h8cc702081a6439ec;
            7'd60: v = 64'h90befffa23631e28;
            7'd61: v = 64'ha4506cebde82bde9;
            7'd62: v = 64'hbef9a3f7b2c67915;
            7'd63: v = 64'hc67178f2e372532b;
            7'd64: v = 64'hca273eceea26619c;
            7'd65: v = 64'hd186b8c721c0c207;
            7'd66: v = 64'heada7dd6cde0eb1e;
            7'd67: v = 64'hf57d4f7fee6ed178;
            7'd68: v = 64'h06f067aa72176fba;
            7'd69: v = 64'h0a637dc5a2c898a6;
            7'd70: v = 64'h113f9804bef90dae;
            7'd71: v = 64'h1b710b35131c471b;
            7'd72: v = 64'h28db77f523047d84;
            7'd73: v = 64'h32caab7b40c72493;
            7'd74: v = 64'h3c9ebe0a15c9bebc;
            7'd75: v = 64'h431d67c49c100d4c;
            7'd76: v = 64'h4cc5d4becb3e42b6;
            7'd77: v = 64'h597f299cfc657e2a;
            7'd78: v = 64'h5fcb6fab3ad6faec;
            7'd79: v = 64'h6c44198c4a475817;
            default: v = 64'h0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/sha512_stream_hasher.sv
// SHA-512 engine: absorbs at most one message byte per beat and streams out the digest.
// An input beat is taken only in the idle state; a byte that fills a 128-byte block
// runs the rounds on the shared round unit and the chaining add with tready low.
// A message end pads with 0x80, zeros and the length, running the rounds per block filled,
// then gives eight digest beats, one per cycle while m_axis_tready is high.
// Synchronous active-low reset loads the initial hash values and clears the counts.
module sha512_stream_hasher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  sha512sh_pkg::t_byte  s_axis_tdata,   // [7:0] data_byte
    input  logic                 s_axis_tuser,   // [0] byte_present
    input  logic                 s_axis_tlast,   // message_end
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output sha512sh_pkg::t_word  m_axis_tdata,   // [63:0] digest_word
    output sha512sh_pkg::t_widx  m_axis_tuser,   // [2:0] word_index
    output logic                 m_axis_tlast    // last_word
);
    import sha512sh_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    t_fill  r_fill, n_fill;
    t_word  r_total, n_total;
    t_round r_rnd, n_rnd;
    t_widx  r_oidx, n_oidx;
    t_word  r_chain [8];
    t_word  n_chain [8];
    t_work  r_work, n_work;
    logic [1023:0] r_blk, n_blk;

    logic   in_beat;
    logic   out_beat;
    logic   wr_en;
    t_byte  wr_byte;
    t_state after_wr;
    t_word  len_bits;
    t_byte  len_byte;
    t_work  round_out;
    t_word  sched_word;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_chain[r_oidx];
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == WORD_LAST);

    // The length bytes fill offsets 112 to 127; the first eight are the zero upper half.
    assign len_bits = {r_total[60:0], 3'b000};
    assign len_byte = r_fill[3] ? len_bits[{~r_fill[2:0], 3'b000} +: 8] : 8'h00;

    // The block buffer doubles as the sliding schedule window; word 0 sits at the top.
    sha512sh_round u_round (
        .i_work  (r_work),
        .i_k     (round_k(r_rnd)),
        .i_w0    (r_blk[1023:960]),
        .i_w1    (r_blk[959:896]),
        .i_w9    (r_blk[447:384]),
        .i_w14   (r_blk[127:64]),
        .o_work  (round_out),
        .o_sched (sched_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_fill  <= '0;
            r_total <= '0;
            r_rnd   <= '0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= iv_word(3'(i));
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_total <= n_total;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
            r_chain <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_blk  <= n_blk;
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_fill   = r_fill;
        n_total  = r_total;
        n_rnd    = r_rnd;
        n_oidx   = r_oidx;
        n_chain  = r_chain;
        n_work   = r_work;
        n_blk    = r_blk;
        wr_en    = 1'b0;
        wr_byte  = 8'h00;
        after_wr = r_state;

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (s_axis_tuser) begin
                        wr_en   = 1'b1;
                        wr_byte = s_axis_tdata;
                        n_total = r_total + 64'd1;
                    end
                    after_wr = s_axis_tlast ? S_PAD_ONE : S_IDLE;
                end
            end
            S_PAD_ONE: begin
                wr_en    = 1'b1;
                wr_byte  = PAD_BYTE;
                after_wr = (r_fill == LEN_OFFSET - 7'd1) ? S_PAD_LEN : S_PAD_ZERO;
            end
            S_PAD_ZERO: begin
                if (r_fill == LEN_OFFSET) begin
                    after_wr = S_PAD_LEN;
                end else begin
                    wr_en = 1'b1;
                end
            end
            S_PAD_LEN: begin
                wr_en    = 1'b1;
                wr_byte  = len_byte;
                after_wr = (r_fill == FILL_LAST) ? S_OUT : S_PAD_LEN;
            end
            S_ROUND: begin
                n_work = round_out;
                n_blk  = {r_blk[959:0], sched_word};
                n_rnd  = r_rnd + 7'd1;
                if (r_rnd == ROUND_LAST) begin
                    after_wr = S_FINAL;
                end
            end
            S_FINAL: begin
                n_chain[0] = r_chain[0] + r_work.a;
                n_chain[1] = r_chain[1] + r_work.b;
                n_chain[2] = r_chain[2] + r_work.c;
                n_chain[3] = r_chain[3] + r_work.d;
                n_chain[4] = r_chain[4] + r_work.e;
                n_chain[5] = r_chain[5] + r_work.f;
                n_chain[6] = r_chain[6] + r_work.g;
                n_chain[7] = r_chain[7] + r_work.h;
                after_wr   = r_ret;
            end
            S_OUT: begin
                if (out_beat) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == WORD_LAST) begin
                        for (int i = 0; i < 8; i++) begin
                            n_chain[i] = iv_word(3'(i));
                        end
                        n_fill   = '0;
                        n_total  = '0;
                        after_wr = S_IDLE;
                    end
                end
            end
            default: begin
                after_wr = S_IDLE;
            end
        endcase

        n_state = after_wr;

        // Every byte, message or padding, shifts in here; a full block starts the rounds.
        if (wr_en) begin
            n_blk  = {r_blk[1015:0], wr_byte};
            n_fill = r_fill + 7'd1;
            if (r_fill == FILL_LAST) begin
                n_state  = S_ROUND;
                n_ret    = after_wr;
                n_rnd    = '0;
                n_work.a = r_chain[0];
                n_work.b = r_chain[1];
                n_work.c = r_chain[2];
                n_work.d = r_chain[3];
                n_work.e = r_chain[4];
                n_work.f = r_chain[5];
                n_work.g = r_chain[6];
                n_work.h = r_chain[7];
            end
        end
    end

endmodule

// File: hw/rtl/sha512sh_round.sv
// One SHA-512 compression round plus the next message schedule word.
module sha512sh_round (
    input  sha512sh_pkg::t_work i_work,
    input  sha512sh_pkg::t_word i_k,
    input  sha512sh_pkg::t_word i_w0,
    input  sha512sh_pkg::t_word i_w1,
    input  sha512sh_pkg::t_word i_w9,
    input  sha512sh_pkg::t_word i_w14,
    output sha512sh_pkg::t_work o_work,
    output sha512sh_pkg::t_word o_sched
);
    import sha512sh_pkg::*;

    t_word sum1;
    t_word sum0;
    t_word choose;
    t_word major;
    t_word t1;
    t_word sig0;
    t_word sig1;

    always_comb begin
        sum1   = rotr64(i_work.e, 14) ^ rotr64(i_work.e, 18) ^ rotr64(i_work.e, 41);
        choose = (i_work.e & i_work.f) ^ (~i_work.e & i_work.g);
        t1     = i_work.h + sum1 + choose + i_k + i_w0;
        sum0   = rotr64(i_work.a, 28) ^ rotr64(i_work.a, 34) ^ rotr64(i_work.a, 39);
        major  = (i_work.a & i_work.b) ^ (i_work.a & i_work.c) ^ (i_work.b & i_work.c);

        o_work.a = t1 + sum0 + major;
        o_work.b = i_work.a;
        o_work.c = i_work.b;
        o_work.d = i_work.c;
        o_work.e = i_work.d + t1;
        o_work.f = i_work.e;
        o_work.g = i_work.f;
        o_work.h = i_work.g;
    end

    // Word sixteen places ahead in the schedule, built from the sliding window.
    always_comb begin
        sig0    = rotr64(i_w1, 1) ^ rotr64(i_w1, 8) ^ (i_w1 >> 7);
        sig1    = rotr64(i_w14, 19) ^ rotr64(i_w14, 61) ^ (i_w14 >> 6);
        o_sched = i_w0 + sig0 + i_w9 + sig1;
    end

endmodule

// File: hw/rtl/sha512sh_checker.sv
// Port-level checks of the SHA-512 stream hasher and their bind.
`include "sha512_stream_hasher_macros.svh"

module sha512sh_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input sha512sh_pkg::t_word m_axis_tdata,
    input sha512sh_pkg::t_widx m_axis_tuser,
    input logic                m_axis_tlast
);
    import sha512sh_pkg::*;

    // The engine never takes input while it still owes digest beats.
    `SHA512SH_ASSERT(a_no_overlap, !(m_axis_tvalid && s_axis_tready), "input taken during digest output")

    `SHA512SH_ASSERT(a_last_matches_index, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == WORD_LAST)), "tlast not on word seven")

    `SHA512SH_ASSERT(a_index_steps, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1)), "digest words not back to back in order")

    `SHA512SH_ASSERT(a_out_holds, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled digest beat changed")

    // After the final digest beat the engine is idle and ready for a new message.
    `SHA512SH_ASSERT(a_back_to_idle, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (!m_axis_tvalid && s_axis_tready), "engine not idle after digest")

endmodule

bind sha512_stream_hasher sha512sh_checker u_checker (.*);

// File: verif/sha512_stream_hasher_tb.sv
// Self-checking testbench for the SHA-512 stream hasher: random message streams, digest checking.
`timescale 1ns / 1ps

module sha512_stream_hasher_tb;
    import sha512sh_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_BEATS = 220;
    localparam int LONG_ROOM = 150;

    localparam logic [63:0] ROUND_CONST [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] INIT_CHAIN [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    typedef struct packed {
        t_byte data;
        logic  present;
        logic  last;
    } t_msg_beat;

    typedef struct {
        t_word word;
        t_widx idx;
        logic  last;
    } t_digest_beat;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  s_axis_tvalid = 1'b0;
    logic  s_axis_tready;
    t_byte s_axis_tdata = '0;
    logic  s_axis_tuser = 1'b0;
    logic  s_axis_tlast = 1'b0;
    logic  m_axis_tvalid;
    logic  m_axis_tready = 1'b0;
    t_word m_axis_tdata;
    t_widx m_axis_tuser;
    logic  m_axis_tlast;

    sha512_stream_hasher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the hashing state.
    t_word hash_chain [0:7];
    t_word block_words [0:15];
    int    block_fill;
    t_word bytes_seen;

    t_msg_beat    msg_beats [$];
    t_digest_beat digest_expect [$];

    int total_beats;
    int beats_taken;
    int messages_done;
    int words_checked;
    int errors;
    int cycle_count;

    function automatic t_word ror64(input t_word x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic compress_block();
        t_word w [0:79];
        t_word a, b, c, d, e, f, g, h, t1, t2;
        int i;
        for (i = 0; i < 16; i++) w[i] = block_words[i];
        for (i = 16; i < 80; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7))
                 + (ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6));
        end
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
        e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
        for (i = 0; i < 80; i++) begin
            t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & f) ^ (~e & g))
               + ROUND_CONST[i] + w[i];
            t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
        hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
    endtask

    // Bytes land big-endian in the block words; a full block is compressed at once.
    task automatic load_block_byte(input t_byte value);
        block_words[block_fill / 8][8 * (7 - block_fill % 8) +: 8] = value;
        block_fill++;
        if (block_fill == 128) begin
            compress_block();
            block_fill = 0;
        end
    endtask

    task automatic hash_reset();
        int i;
        for (i = 0; i < 8; i++) hash_chain[i] = INIT_CHAIN[i];
        block_fill = 0;
        bytes_seen = '0;
    endtask

    task automatic hash_accept_beat(input t_msg_beat beat);
        t_word bit_len;
        t_digest_beat want;
        int i;
        if (beat.present) begin
            load_block_byte(beat.data);
            bytes_seen++;
        end
        if (beat.last) begin
            bit_len = bytes_seen << 3;
            load_block_byte(PAD_BYTE);
            while (block_fill != 112) load_block_byte(8'h00);
            for (i = 0; i < 8; i++) load_block_byte(8'h00);
            for (i = 0; i < 8; i++) load_block_byte(bit_len[8 * (7 - i) +: 8]);
            for (i = 0; i < 8; i++) begin
                want.word = hash_chain[i];
                want.idx  = t_widx'(i);
                want.last = (i == 7);
                digest_expect.push_back(want);
            end
            hash_reset();
        end
    endtask

    task automatic queue_beat(input t_byte data, input logic present, input logic last);
        t_msg_beat beat;
        beat.data = data;
        beat.present = present;
        beat.last = last;
        msg_beats.push_back(beat);
    endtask

    // Source side: one beat on the bus at a time, random gaps between beats.
    t_msg_beat on_bus;
    int        src_gap = 0;
    bit        src_quiet = 1'b0;

    always @(posedge i_clk) begin : source
        logic held;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                hash_accept_beat(on_bus);
                beats_taken++;
                if (on_bus.last) messages_done++;
                if ($urandom_range(0, 29) == 0) src_quiet = !src_quiet;
            end
            held = s_axis_tvalid && !s_axis_tready;
            if (!held) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (msg_beats.size() > 0) begin
                    on_bus = msg_beats.pop_front();
                    s_axis_tdata  <= on_bus.data;
                    s_axis_tuser  <= on_bus.present;
                    s_axis_tlast  <= on_bus.last;
                    s_axis_tvalid <= 1'b1;
                    src_gap = pick_gap(src_quiet);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: random back-pressure and digest checking.
    int sink_stall = 0;
    bit sink_quiet = 1'b0;

    always @(posedge i_clk) begin : sink
        t_digest_beat want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_expect.size() == 0) begin
                    $display("%0t: unexpected digest beat: word %h index %0d last %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    errors++;
                end else begin
                    want = digest_expect.pop_front();
                    words_checked++;
                    if (m_axis_tdata !== want.word) begin
                        $display("%0t: digest word mismatch: expected %h, actual %h",
                                 $time, want.word, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser !== want.idx) begin
                        $display("%0t: word index mismatch: expected %0d, actual %0d",
                                 $time, want.idx, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $display("%0t: last word flag mismatch: expected %b, actual %b",
                                 $time, want.last, m_axis_tlast);
                        errors++;
                    end
                end
                if ($urandom_range(0, 19) == 0) sink_quiet = !sink_quiet;
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0) sink_stall = pick_gap(sink_quiet);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d of %0d beats taken",
                     $time, cycle_count, beats_taken, total_beats);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        int msg_len;
        int j;
        bit empty_end;
        hash_reset();
        for (j = 0; j < 16; j++) block_words[j] = '0;

        // Empty message, ended by a beat with no byte.
        queue_beat(8'hff, 1'b0, 1'b1);
        // An ignored beat, then "abc".
        queue_beat(8'h00, 1'b0, 1'b0);
        queue_beat(8'h61, 1'b1, 1'b0);
        queue_beat(8'h62, 1'b1, 1'b0);
        queue_beat(8'h63, 1'b1, 1'b1);
        // Single-byte messages at the data extremes.
        queue_beat(8'h00, 1'b1, 1'b1);
        queue_beat(8'hff, 1'b1, 1'b1);
        // Bytes followed by an end beat that carries no byte.
        queue_beat(8'hff, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b1, 1'b0);
        queue_beat(8'h5a, 1'b0, 1'b1);
        // An ignored beat in the middle of a message.
        queue_beat(8'h5a, 1'b1, 1'b0);
        queue_beat(8'ha5, 1'b0, 1'b0);
        queue_beat(8'ha5, 1'b1, 1'b1);

        // Random messages: mostly short, some long enough to cross the padding boundary.
        // Long ones are only drawn while they still fit the beat budget.
        while (msg_beats.size() < RANDOM_BEATS) begin
            if (msg_beats.size() + LONG_ROOM < RANDOM_BEATS && $urandom_range(0, 1) == 0)
                msg_len = $urandom_range(104, 130);
            else msg_len = $urandom_range(0, 20);
            empty_end = (msg_len == 0) || ($urandom_range(0, 4) == 0);
            for (j = 0; j < msg_len; j++) begin
                if ($urandom_range(0, 9) == 0)
                    queue_beat(t_byte'($urandom_range(0, 255)), 1'b0, 1'b0);
                queue_beat(t_byte'($urandom_range(0, 255)), 1'b1,
                           !empty_end && (j == msg_len - 1));
            end
            if (empty_end) queue_beat(t_byte'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        total_beats = msg_beats.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < total_beats || digest_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d input beats forming %0d messages; checked %0d digest words.",
                 beats_taken, messages_done, words_checked);
        $display("Errors seen: %0d", errors);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
